>>> hdl/p2rt_pkg.sv
// Package for the pose-to-rigid-transform pipeline.
// Shared widths, divider request type and the Q.60 to Q1.16 reduction.
// No dependencies.
package p2rt_pkg;

   localparam int NUM_COMP   = 4;   // w, x, y, z
   localparam int DIV_STEPS  = 31;
   localparam int DIV_STAGES = DIV_STEPS + 2;
   localparam int SQ_STAGES  = 2;
   localparam int MAT_STAGES = 2;
   localparam int LATENCY    = SQ_STAGES + DIV_STAGES + MAT_STAGES;

   typedef logic [63:0]        wide_type;
   typedef logic signed [31:0] comp_type;
   typedef logic signed [17:0] entry_type;

   typedef struct packed {
      logic [NUM_COMP-1:0]    neg;
      wide_type [NUM_COMP-1:0] num;
      wide_type               den;
   } div_req_type;

   localparam logic signed [65:0] ONE_Q60  = 66'sd1152921504606846976;
   localparam logic signed [65:0] HALF_Q44 = 66'sd8796093022208;
   localparam logic signed [65:0] SAT_POS  = 66'sd65536;
   localparam logic signed [65:0] SAT_NEG  = -66'sd65536;

   // round to nearest (ties up) from Q.60 to Q.16, then saturate to [-1, 1]
   function automatic entry_type to_q16(input logic signed [65:0] v);
      logic signed [65:0] t;
      logic signed [65:0] q;
      t = v + HALF_Q44;
      q = t >>> 44;
      if (q > SAT_POS) begin
         q = SAT_POS;
      end else if (q < SAT_NEG) begin
         q = SAT_NEG;
      end
      return q[17:0];
   endfunction

endpackage

>>> hdl/p2rt_sqsum.sv
// Front end: magnitudes, squares, sum of squares and divider operands.
// Depends on p2rt_pkg.
module p2rt_sqsum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [95:0]          in_param,   // x [31:0], y [63:32], z [95:64]
   output logic                 out_valid,
   output p2rt_pkg::div_req_type out_req
);
   import p2rt_pkg::*;

   logic                 v1_ff, v2_ff;
   wide_type [2:0]       sq_ff, sq_in;
   logic [2:0][31:0]     mag_ff, mag_in;
   logic [2:0]           neg_ff, neg_in;
   div_req_type          req_ff, req_in;
   wide_type             s;
   logic                 wneg;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = in_param[32*i+31];
         mag_in[i] = neg_in[i] ? (32'd0 - in_param[32*i +: 32]) : in_param[32*i +: 32];
         sq_in[i]  = 64'(mag_in[i]) * 64'(mag_in[i]);
      end
   end

   always_comb begin
      s    = sq_ff[0] + sq_ff[1] + sq_ff[2];
      wneg = s > 64'h1_0000_0000;
      req_in.den    = s + 64'h1_0000_0000;
      req_in.neg[0] = wneg;
      req_in.num[0] = wneg ? (s - 64'h1_0000_0000) : (64'h1_0000_0000 - s);
      for (int i = 0; i < 3; i++) begin
         req_in.neg[i+1] = neg_ff[i];
         req_in.num[i+1] = {15'd0, mag_ff[i], 17'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff  <= sq_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         req_ff <= req_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_req   = req_ff;

endmodule

>>> hdl/p2rt_div.sv
// Pipelined restoring divider: four quotients num * 2^30 / den, one bit per stage,
// rounded half away from zero and signed. Depends on p2rt_pkg.
module p2rt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  p2rt_pkg::div_req_type in_req,
   output logic                  out_valid,
   output p2rt_pkg::comp_type    out_comp [p2rt_pkg::NUM_COMP]
);
   import p2rt_pkg::*;

   localparam int NS = DIV_STEPS + 1;

   logic [NS-1:0]          v_ff, v_in;
   wide_type               d_ff   [NS], d_in   [NS];
   logic [NUM_COMP-1:0]    n_ff   [NS], n_in   [NS];
   wide_type               r_ff   [NS][NUM_COMP], r_in [NS][NUM_COMP];
   logic [31:0]            q_ff   [NS][NUM_COMP], q_in [NS][NUM_COMP];
   comp_type               c_ff   [NUM_COMP], c_in [NUM_COMP];
   logic                   vo_ff;

   always_comb begin
      logic [64:0] r2;
      logic [32:0] qr;
      v_in[0] = in_valid;
      d_in[0] = in_req.den;
      n_in[0] = in_req.neg;
      for (int c = 0; c < NUM_COMP; c++) begin
         if (in_req.num[c] >= in_req.den) begin
            r_in[0][c] = in_req.num[c] - in_req.den;
            q_in[0][c] = 32'd1;
         end else begin
            r_in[0][c] = in_req.num[c];
            q_in[0][c] = 32'd0;
         end
      end
      for (int k = 1; k < NS; k++) begin
         v_in[k] = v_ff[k-1];
         d_in[k] = d_ff[k-1];
         n_in[k] = n_ff[k-1];
         for (int c = 0; c < NUM_COMP; c++) begin
            r2 = {r_ff[k-1][c], 1'b0};
            if (r2 >= {1'b0, d_ff[k-1]}) begin
               r_in[k][c] = 64'(r2 - {1'b0, d_ff[k-1]});
               q_in[k][c] = {q_ff[k-1][c][30:0], 1'b1};
            end else begin
               r_in[k][c] = r2[63:0];
               q_in[k][c] = {q_ff[k-1][c][30:0], 1'b0};
            end
         end
      end
      for (int c = 0; c < NUM_COMP; c++) begin
         qr      = ({1'b0, q_ff[NS-1][c]} + 33'd1) >> 1;
         c_in[c] = n_ff[NS-1][c] ? (32'sd0 - $signed(qr[31:0])) : $signed(qr[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= v_in;
         vo_ff <= v_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
         n_ff <= n_in;
         r_ff <= r_in;
         q_ff <= q_in;
         c_ff <= c_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_comp  = c_ff;

endmodule

>>> hdl/p2rt_mat.sv
// Rotation matrix back end: quaternion products, then sums, rounding and
// saturation to Q1.16. Depends on p2rt_pkg.
module p2rt_mat (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  p2rt_pkg::comp_type in_comp [p2rt_pkg::NUM_COMP],
   output logic               out_valid,
   output p2rt_pkg::entry_type out_rot [9]
);
   import p2rt_pkg::*;

   logic               pv_ff, ov_ff;
   logic signed [63:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   entry_type          rot_ff [9], rot_in [9];

   always_comb begin
      logic signed [65:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
      xx = 66'(xx_ff); yy = 66'(yy_ff); zz = 66'(zz_ff);
      xy = 66'(xy_ff); xz = 66'(xz_ff); yz = 66'(yz_ff);
      wx = 66'(wx_ff); wy = 66'(wy_ff); wz = 66'(wz_ff);
      rot_in[0] = to_q16(ONE_Q60 - 2 * (yy + zz));
      rot_in[1] = to_q16(2 * (xy - wz));
      rot_in[2] = to_q16(2 * (xz + wy));
      rot_in[3] = to_q16(2 * (xy + wz));
      rot_in[4] = to_q16(ONE_Q60 - 2 * (xx + zz));
      rot_in[5] = to_q16(2 * (yz - wx));
      rot_in[6] = to_q16(2 * (xz - wy));
      rot_in[7] = to_q16(2 * (yz + wx));
      rot_in[8] = to_q16(ONE_Q60 - 2 * (xx + yy));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= in_valid;
         ov_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff  <= 64'(in_comp[1]) * 64'(in_comp[1]);
         yy_ff  <= 64'(in_comp[2]) * 64'(in_comp[2]);
         zz_ff  <= 64'(in_comp[3]) * 64'(in_comp[3]);
         xy_ff  <= 64'(in_comp[1]) * 64'(in_comp[2]);
         xz_ff  <= 64'(in_comp[1]) * 64'(in_comp[3]);
         yz_ff  <= 64'(in_comp[2]) * 64'(in_comp[3]);
         wx_ff  <= 64'(in_comp[0]) * 64'(in_comp[1]);
         wy_ff  <= 64'(in_comp[0]) * 64'(in_comp[2]);
         wz_ff  <= 64'(in_comp[0]) * 64'(in_comp[3]);
         rot_ff <= rot_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_rot   = rot_ff;

endmodule

>>> hdl/pose_to_rigid_transform.sv
// Top level: pose (three rotation parameters, translation) to rigid transform.
// Instantiates p2rt_sqsum, p2rt_div and p2rt_mat; depends on p2rt_pkg.
//
// Usage:
//   req_* carries one pose per transaction, rsp_* one rotation matrix in Q1.16
//   plus the unchanged translation. One response per request, in order.
//   From accepted request to rsp_tvalid a pose passes squares and sum, the
//   one-bit-per-stage quaternion divider with its 32 quotient stages, then
//   products and final rounding.
//   Throughput is one transaction per cycle while rsp_tready is high.
//   The whole pipeline advances on one enable; when rsp_tvalid is high and
//   rsp_tready low, every stage holds and req_tready drops, so nothing is
//   lost or repeated. Bubbles travel as cleared valid bits.
//   Reset clears all valid bits; no response is pending after reset.
module pose_to_rigid_transform (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rot_param_x, rot_param_y, rot_param_z, trans_x, trans_y, trans_z (32b each)
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rot_00..rot_22 (18b each), out_trans_x, out_trans_y, out_trans_z (32b), pad
   output logic [263:0] rsp_tdata
);
   import p2rt_pkg::*;

   logic        en;
   logic        sq_valid, div_valid;
   div_req_type sq_req;
   comp_type    comp [NUM_COMP];
   entry_type   rot [9];
   logic [95:0] trans_ff [LATENCY];

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   p2rt_sqsum u_sqsum (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_param  (req_tdata[95:0]),
      .out_valid (sq_valid),
      .out_req   (sq_req)
   );

   p2rt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_req    (sq_req),
      .out_valid (div_valid),
      .out_comp  (comp)
   );

   p2rt_mat u_mat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_comp   (comp),
      .out_valid (rsp_tvalid),
      .out_rot   (rot)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         trans_ff[0] <= req_tdata[191:96];
         for (int k = 1; k < LATENCY; k++) begin
            trans_ff[k] <= trans_ff[k-1];
         end
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < 9; i++) begin
         rsp_tdata[18*i +: 18] = rot[i];
      end
      rsp_tdata[257:162] = trans_ff[LATENCY-1];
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_diag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[17:0]) >= -18'sd65536 &&
                      $signed(rsp_tdata[89:72]) >= -18'sd65536 &&
                      $signed(rsp_tdata[161:144]) >= -18'sd65536 &&
                      rsp_tdata[17] == 1'b0 || rsp_tdata[16:0] != 17'd0 ||
                      $signed(rsp_tdata[17:0]) == -18'sd65536))
      else $error("diagonal entry out of range");

   a_offdiag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[35:18]) <= 18'sd65536 &&
                      $signed(rsp_tdata[35:18]) >= -18'sd65536))
      else $error("off-diagonal entry out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("pipeline moved during stall");

endmodule
